FILE: hw/rtl/csemwq_pkg.sv
// ----------------------------------------------------------------------------
// csemwq_pkg - shared types and constants for the counting semaphore
// Field widths, operation and status codes and parameter defaults.
// ----------------------------------------------------------------------------
package csemwq_pkg;

    // Default sizes of the wait queue, the holder table and the id width
    localparam int DEF_WAIT_DEPTH   = 16;
    localparam int DEF_HOLDER_DEPTH = 16;
    localparam int DEF_PID_BITS     = 8;

    // Fixed field widths on the stream ports
    localparam int PID_FIELD_W = 8;
    localparam int PID_EXT_W   = 16;
    localparam int COUNT_W     = 8;
    localparam int STATUS_W    = 2;
    localparam int IN_DATA_W   = 8;
    localparam int IN_USER_W   = 1;
    localparam int OUT_DATA_W  = 24;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

    typedef enum logic
    {
        OP_ACQUIRE = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_OK          = 2'd0,
        ST_QUEUE_FULL  = 2'd1,
        ST_HOLDER_FULL = 2'd2,
        ST_NOT_HOLDER  = 2'd3
    } status_t;

endpackage

FILE: hw/rtl/counting_semaphore_wait_queue.sv
// ----------------------------------------------------------------------------
// counting_semaphore_wait_queue - counting semaphore with FIFO wait queue
// Acquire/release operations against a permit count, a holder table and
// an ordered wait queue, one result transaction per operation.
// ----------------------------------------------------------------------------
// Each transaction on the slave stream is one operation: tuser[0] selects
// acquire (0) or release (1) and tdata[7:0] carries the requester id. Every
// operation yields exactly one result transaction. An operation passes
// through an input register and is resolved from it into the result
// register, so the block takes one operation per clock while the master
// side takes results; throughput is set only by that side. The holder table is
// searched by a parallel compare across all slots and the wait queue is a
// pointer-based ring whose head entry is kept prefetched in a register.
// The permit count resets to 1; a write on the cfg channel loads the count
// directly and must be issued only while no operation is in flight.
// ----------------------------------------------------------------------------
module counting_semaphore_wait_queue
#(
    parameter int WAIT_DEPTH   = csemwq_pkg::DEF_WAIT_DEPTH,
    parameter int HOLDER_DEPTH = csemwq_pkg::DEF_HOLDER_DEPTH,
    parameter int PID_BITS     = csemwq_pkg::DEF_PID_BITS
)
(
    input  logic                               clk,
    input  logic                               rst_n,

    // Operation stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [csemwq_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // [7:0] pid
    input  logic [csemwq_pkg::IN_USER_W-1:0]   s_axis_tuser,  // [0] operation

    // Result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [csemwq_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // [0] granted,
                                                               // [1] woken_valid,
                                                               // [9:2] woken_pid,
                                                               // [17:10] count_after,
                                                               // [19:18] status,
                                                               // [23:20] zero

    // Initial count register write
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [csemwq_pkg::COUNT_W-1:0]     cfg_data
);

    import csemwq_pkg::*;

    localparam int IdW  = PID_BITS;
    localparam int PtrW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int OccW = $clog2(WAIT_DEPTH + 1);
    localparam int HD   = HOLDER_DEPTH;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic                   in_valid_reg;
    op_t                    op_reg;
    logic [IdW-1:0]         id_reg;

    logic [COUNT_W-1:0]     count_reg,  count_next;
    logic [PtrW-1:0]        head_reg,   head_next;
    logic [PtrW-1:0]        tail_reg,   tail_next;
    logic [OccW-1:0]        occ_reg,    occ_next;
    logic [HD-1:0]          hv_reg,     hv_next;
    logic [IdW-1:0]         hid_reg [HD];
    logic [IdW-1:0]         head_data_reg;
    logic [IdW-1:0]         wait_mem [WAIT_DEPTH];

    logic                   out_valid_reg;
    logic                   granted_reg,     granted_next;
    logic                   woken_valid_reg, woken_valid_next;
    logic [IdW-1:0]         woken_id_reg,    woken_id_next;
    logic [COUNT_W-1:0]     count_out_reg;
    status_t                status_reg,      status_next;

    // Combinational helpers
    logic                   out_free;
    logic                   process;
    logic [PID_EXT_W-1:0]   pid_ext;
    logic [PID_EXT_W-1:0]   woken_ext;
    logic [HD-1:0]          match_vec;
    logic [HD-1:0]          match_oh;
    logic [HD-1:0]          free_oh;
    logic [HD-1:0]          hv_rel;
    logic [HD-1:0]          free_rel_oh;
    logic [COUNT_W-1:0]     count_inc;
    logic [HD-1:0]          hid_wr_oh;
    logic [IdW-1:0]         hid_wr_data;
    logic                   push;
    logic                   pop;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign process       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign cfg_ready     = 1'b1;

    // Take the low PID_BITS of the incoming id
    assign pid_ext = PID_EXT_W'(s_axis_tdata[PID_FIELD_W-1:0]);

    // ------------------------------------------------------------------
    // Capture the operation
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            op_reg <= op_t'(s_axis_tuser[0]);
            id_reg <= pid_ext[IdW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Holder table search: lowest matching slot and lowest free slot
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < HD; i++)
        begin
            match_vec[i] = hv_reg[i] && (hid_reg[i] == id_reg);
        end
    end

    assign match_oh    = match_vec & (~match_vec + HD'(1));
    assign free_oh     = ~hv_reg & (hv_reg + HD'(1));
    assign hv_rel      = hv_reg & ~match_oh;
    assign free_rel_oh = ~hv_rel & (hv_rel + HD'(1));
    assign count_inc   = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + COUNT_W'(1);

    // ------------------------------------------------------------------
    // Resolve one operation
    // ------------------------------------------------------------------
    always_comb
    begin
        count_next       = count_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        occ_next         = occ_reg;
        hv_next          = hv_reg;
        hid_wr_oh        = '0;
        hid_wr_data      = id_reg;
        push             = 1'b0;
        pop              = 1'b0;
        granted_next     = 1'b0;
        woken_valid_next = 1'b0;
        woken_id_next    = '0;
        status_next      = ST_OK;

        if (process)
        begin
            case (op_reg)
                OP_ACQUIRE:
                begin
                    if (count_reg != '0)
                    begin
                        if (free_oh == '0)
                        begin
                            status_next = ST_HOLDER_FULL;
                        end
                        else
                        begin
                            count_next   = count_reg - COUNT_W'(1);
                            hv_next      = hv_reg | free_oh;
                            hid_wr_oh    = free_oh;
                            granted_next = 1'b1;
                        end
                    end
                    else if (occ_reg == OccW'(WAIT_DEPTH))
                    begin
                        status_next = ST_QUEUE_FULL;
                    end
                    else
                    begin
                        push      = 1'b1;
                        tail_next = (tail_reg == PtrW'(WAIT_DEPTH - 1)) ?
                                    '0 : tail_reg + PtrW'(1);
                        occ_next  = occ_reg + OccW'(1);
                    end
                end
                OP_RELEASE:
                begin
                    count_next  = count_inc;
                    hv_next     = hv_rel;
                    status_next = (match_vec != '0) ? ST_OK : ST_NOT_HOLDER;
                    // Hand the permit to the oldest waiter
                    if (occ_reg != '0)
                    begin
                        if (free_rel_oh == '0)
                        begin
                            status_next = ST_HOLDER_FULL;
                        end
                        else
                        begin
                            pop              = 1'b1;
                            head_next        = (head_reg == PtrW'(WAIT_DEPTH - 1)) ?
                                               '0 : head_reg + PtrW'(1);
                            occ_next         = occ_reg - OccW'(1);
                            count_next       = count_inc - COUNT_W'(1);
                            hv_next          = hv_rel | free_rel_oh;
                            hid_wr_oh        = free_rel_oh;
                            hid_wr_data      = head_data_reg;
                            woken_valid_next = 1'b1;
                            woken_id_next    = head_data_reg;
                        end
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_W'(1);
            head_reg  <= '0;
            tail_reg  <= '0;
            occ_reg   <= '0;
            hv_reg    <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            occ_reg  <= occ_next;
            hv_reg   <= hv_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
            else
            begin
                count_reg <= count_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Holder ids: write the chosen slot
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < HD; i++)
        begin
            if (hid_wr_oh[i])
            begin
                hid_reg[i] <= hid_wr_data;
            end
        end
    end

    // ------------------------------------------------------------------
    // Wait queue memory; prefetch the head entry, forward a same-cycle write
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            wait_mem[tail_reg] <= id_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && (tail_reg == head_next))
        begin
            head_data_reg <= id_reg;
        end
        else
        begin
            head_data_reg <= wait_mem[head_next];
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            granted_reg     <= granted_next;
            woken_valid_reg <= woken_valid_next;
            woken_id_reg    <= woken_id_next;
            count_out_reg   <= count_next;
            status_reg      <= status_next;
        end
    end

    assign woken_ext     = PID_EXT_W'(woken_id_reg);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000,
                            status_reg,
                            count_out_reg,
                            woken_ext[PID_FIELD_W-1:0],
                            woken_valid_reg,
                            granted_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OccW'(WAIT_DEPTH))
        else $error("wait queue occupancy above depth");

    a_ptr_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == tail_reg) == ((occ_reg == '0) || (occ_reg == OccW'(WAIT_DEPTH))))
        else $error("queue pointers disagree with occupancy");

    a_grant_wake: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(granted_reg && woken_valid_reg))
        else $error("grant and wake in one result");

    a_wake_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && woken_valid_reg) |->
            (status_reg == ST_OK || status_reg == ST_NOT_HOLDER))
        else $error("wake reported with a full-table or dropped status");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (occ_reg == $past(occ_reg) - OccW'(1)))
        else $error("queue pop did not lower occupancy");

endmodule

FILE: bench/tb_counting_semaphore_wait_queue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_counting_semaphore_wait_queue - self-checking bench for the semaphore
// Drives acquire/release transactions on the operation stream, with bursts,
// gaps and a stalling result side. A scoreboard keeps its own permit count,
// holder table and wait queue and checks every result transaction field by
// field. Several initial_count settings are loaded between phases.
// ----------------------------------------------------------------------------
module tb_counting_semaphore_wait_queue;

    import csemwq_pkg::*;

    localparam int WAIT_SLOTS   = DEF_WAIT_DEPTH;
    localparam int HOLDER_SLOTS = DEF_HOLDER_DEPTH;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE       = 4;

    // One predicted result transaction
    typedef struct
    {
        logic                granted;
        logic                woken;
        logic [7:0]          woken_pid;
        logic [COUNT_W-1:0]  count;
        status_t             status;
    } outcome_t;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts each operation and checks results in order
    // ------------------------------------------------------------------------
    class semaphore_scoreboard;
        logic [COUNT_W-1:0] permits;
        logic [7:0]         waiters[$];
        logic [7:0]         holder_id[HOLDER_SLOTS];
        bit                 holder_on[HOLDER_SLOTS];
        outcome_t           expected[$];
        int                 mismatches;
        int                 checked;
        int                 grants;
        int                 wakes;
        int                 status_seen[4];

        function new();
            permits    = 8'd1;
            mismatches = 0;
            checked    = 0;
            grants     = 0;
            wakes      = 0;
            foreach (holder_on[i])
                holder_on[i] = 1'b0;
            foreach (status_seen[i])
                status_seen[i] = 0;
        endfunction

        function void load_count(logic [COUNT_W-1:0] value);
            permits = value;
        endfunction

        function int pending();
            return expected.size();
        endfunction

        function int free_slot();
            for (int i = 0; i < HOLDER_SLOTS; i++)
                if (!holder_on[i])
                    return i;
            return -1;
        endfunction

        // Pick a random current holder id; return 0 when the table is empty
        function bit pick_holder(output logic [7:0] pid);
            int idx[$];
            for (int i = 0; i < HOLDER_SLOTS; i++)
                if (holder_on[i])
                    idx.insert(idx.size(), i);
            pid = 8'd0;
            if (idx.size() == 0)
                return 1'b0;
            pid = holder_id[idx[$urandom_range(0, idx.size() - 1)]];
            return 1'b1;
        endfunction

        // Apply one accepted operation and queue its expected result
        function void note_op(op_t op, logic [7:0] pid);
            outcome_t r;
            int       slot;
            bit       found;
            r.granted   = 1'b0;
            r.woken     = 1'b0;
            r.woken_pid = 8'd0;
            r.status    = ST_OK;
            found       = 1'b0;
            if (op == OP_ACQUIRE)
            begin
                if (permits != 0)
                begin
                    slot = free_slot();
                    if (slot < 0)
                        r.status = ST_HOLDER_FULL;
                    else
                    begin
                        permits         = permits - 1'b1;
                        holder_id[slot] = pid;
                        holder_on[slot] = 1'b1;
                        r.granted       = 1'b1;
                    end
                end
                else if (waiters.size() >= WAIT_SLOTS)
                    r.status = ST_QUEUE_FULL;
                else
                    waiters.insert(waiters.size(), pid);
            end
            else
            begin
                if (permits != COUNT_MAX)
                    permits = permits + 1'b1;
                // clear only the lowest matching slot
                for (int i = 0; i < HOLDER_SLOTS && !found; i++)
                begin
                    if (holder_on[i] && holder_id[i] == pid)
                    begin
                        holder_on[i] = 1'b0;
                        found        = 1'b1;
                    end
                end
                if (!found)
                    r.status = ST_NOT_HOLDER;
                // hand the permit to the oldest waiter if a slot is free
                if (waiters.size() > 0 && permits != 0)
                begin
                    slot = free_slot();
                    if (slot < 0)
                        r.status = ST_HOLDER_FULL;
                    else
                    begin
                        r.woken_pid     = waiters.pop_front();
                        r.woken         = 1'b1;
                        permits         = permits - 1'b1;
                        holder_id[slot] = r.woken_pid;
                        holder_on[slot] = 1'b1;
                    end
                end
            end
            r.count = permits;
            expected.insert(expected.size(), r);
        endfunction

        function void flag(string field, int want, int got);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] result %0d: %s expected 0x%0h, got 0x%0h",
                         $realtime, checked, field, want, got);
        endfunction

        // Compare one result transaction against the oldest prediction
        function void check_result(logic [OUT_DATA_W-1:0] data);
            outcome_t r;
            if (expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result transaction 0x%06h",
                             $realtime, data);
                return;
            end
            r = expected.pop_front();
            if (data[0] !== r.granted)
                flag("granted", r.granted, data[0]);
            if (data[1] !== r.woken)
                flag("woken_valid", r.woken, data[1]);
            if (data[9:2] !== r.woken_pid)
                flag("woken_pid", r.woken_pid, data[9:2]);
            if (data[17:10] !== r.count)
                flag("count_after", r.count, data[17:10]);
            if (data[19:18] !== r.status)
                flag("status", r.status, data[19:18]);
            if (data[23:20] !== 4'd0)
                flag("padding", 0, data[23:20]);
            checked++;
            grants += r.granted;
            wakes  += r.woken;
            status_seen[r.status]++;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;   // [7:0] pid
    logic [IN_USER_W-1:0]   s_axis_tuser  = '0;   // [0] operation
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;         // [0] granted, [1] woken_valid,
                                                  // [9:2] woken_pid,
                                                  // [17:10] count_after,
                                                  // [19:18] status, [23:20] zero
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [COUNT_W-1:0]     cfg_data      = '0;

    semaphore_scoreboard    sb;
    int                     cycle_count   = 0;
    int                     ops_sent      = 0;
    int                     cfg_writes    = 0;
    int                     burst_left    = 0;
    int                     ready_mode    = 0;
    int                     mode_left     = 0;

    always #5 clk = ~clk;

    counting_semaphore_wait_queue dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending());
            $display("counting_semaphore_wait_queue verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result side: check accepted transactions, stall on a changing pattern
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            // switch the stall pattern every so often
            if (mode_left == 0)
            begin
                ready_mode <= $urandom_range(0, 3);
                mode_left  <= $urandom_range(40, 200);
            end
            else
                mode_left <= mode_left - 1;
            case (ready_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= ((cycle_count % 5) < 3);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Operation side
    // ------------------------------------------------------------------------
    function automatic logic [7:0] random_pid();
        if ($urandom_range(0, 99) < 65)
            return 8'($urandom_range(0, 11));
        return 8'($urandom_range(0, 255));
    endfunction

    // Send one operation, note it on acceptance, then maybe idle
    task automatic send_op(input op_t op, input logic [7:0] pid);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pid;
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_op(op, pid);
        ops_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Hold off until every outstanding result has been taken
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_initial_count(input logic [COUNT_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.load_count(value);
        cfg_writes++;
        cfg_valid <= 1'b0;
    endtask

    // Random phase: mostly releases by real holders, some by strangers
    task automatic run_phase(input logic [COUNT_W-1:0] start_count,
                             input int acquire_pct, input int n_ops);
        op_t        op;
        logic [7:0] pid;
        write_initial_count(start_count);
        for (int k = 0; k < n_ops; k++)
        begin
            if ($urandom_range(1, 100) <= acquire_pct)
            begin
                op  = OP_ACQUIRE;
                pid = random_pid();
            end
            else
            begin
                op = OP_RELEASE;
                if ($urandom_range(0, 3) == 0 || !sb.pick_holder(pid))
                    pid = random_pid();
            end
            send_op(op, pid);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // take the only permit, queue one, hand off, stranger release
        send_op(OP_ACQUIRE, 8'h00);
        send_op(OP_ACQUIRE, 8'hFF);
        send_op(OP_RELEASE, 8'h00);
        send_op(OP_RELEASE, 8'h5A);

        // fill the holder table with some duplicate ids, then overflow it
        write_initial_count(8'd16);
        for (int i = 0; i < 15; i++)
            send_op(OP_ACQUIRE, 8'((i % 12) + 1));
        send_op(OP_ACQUIRE, 8'h80);
        send_op(OP_RELEASE, 8'h01);
        send_op(OP_ACQUIRE, 8'h7F);

        // release at full count saturates
        write_initial_count(COUNT_MAX);
        send_op(OP_RELEASE, 8'hC3);

        // waiter present but no holder slot for the handoff
        write_initial_count(8'd0);
        send_op(OP_ACQUIRE, 8'h33);
        send_op(OP_RELEASE, 8'h44);

        // random phases over several count settings
        run_phase(8'd0, 70, 110);
        run_phase(8'd3, 55, 110);
        run_phase(COUNT_MAX, 50, 100);
        run_phase(8'($urandom_range(2, 254)), 60, 110);
        run_phase(8'd1, 50, 110);
        run_phase(8'd0, 45, 110);

        drain_results();
        repeat (8) @(posedge clk);

        $display("ran %0d operations over %0d count loads; %0d results checked",
                 ops_sent, cfg_writes, sb.checked);
        $display("grants %0d, handoffs %0d, ok %0d, queue full %0d, table full %0d, "
                 , sb.grants, sb.wakes, sb.status_seen[ST_OK],
                 sb.status_seen[ST_QUEUE_FULL], sb.status_seen[ST_HOLDER_FULL],
                 "stranger releases %0d", sb.status_seen[ST_NOT_HOLDER]);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("counting_semaphore_wait_queue verification clean");
        else
        begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
            $display("counting_semaphore_wait_queue verification failed");
        end
        $finish;
    end

endmodule
